// ===== hw/rtl/mams_pkg.sv =====
// ----------------------------------------------------------------------------
// mams_pkg
// Shared constants for the multichannel moving-sum scaler: channel limits,
// configuration register indexes and scaling constants.
// ----------------------------------------------------------------------------
package mams_pkg;

    localparam int CHANNELS_DEF = 16;

    // Field widths
    localparam int CH_W    = 4;
    localparam int SMP_W   = 12;
    localparam int SUM_W   = 14;
    localparam int TEN_W   = 9;
    localparam int PRS_W   = 16;
    localparam int PROD_W  = 30;
    localparam int QUO_W   = 17;
    localparam int RECIP_W = 31;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_CH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_CH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHG_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHG_OFF    = 3'd4;

    // Battery scaling: tenths = (sum * 1372 + 0x8000) >> 16
    localparam logic [15:0] BATT_MULT  = 16'd1372;
    localparam logic [PROD_W:0] BATT_ROUND = 31'h8000;

    // Pressure scaling: (sum - 1658) * full_scale / 13263, rounded
    localparam logic [SUM_W-1:0]  PRES_ZERO  = 14'd1658;
    localparam logic [SUM_W-1:0]  PRES_SPAN  = 14'd13263;
    localparam logic [PROD_W-1:0] PRES_ROUND = 30'd6631;

    // ceil(2^44 / 13263): exact floor division for any 30-bit dividend
    localparam int                 RECIP_SH   = 44;
    localparam logic [RECIP_W-1:0] PRES_RECIP = 31'd1326410771;

    // Reset values of the configuration registers
    localparam logic [15:0]      RST_FULL_SCALE = 16'd0;
    localparam logic [CH_W-1:0]  RST_BATT_CH    = 4'd0;
    localparam logic [CH_W-1:0]  RST_PRES_CH    = 4'd1;
    localparam logic [TEN_W-1:0] RST_CHG_ON     = 9'd260;
    localparam logic [TEN_W-1:0] RST_CHG_OFF    = 9'd255;

endpackage

// ===== hw/rtl/multichannel_adc_moving_sum_scaler.sv =====
// ----------------------------------------------------------------------------
// multichannel_adc_moving_sum_scaler
// Four-sample moving sum per ADC channel with battery and pressure scaling.
//
// Use:
//   Slave stream carries one sample per transfer: tdata = {sample, channel}.
//   Master stream returns one result per sample: tdata = {pressure_scaled,
//   charge_ok, battery_tenths, window_sum, channel_out}, zero padded.
//   The config channel writes one register per transfer (valid/ready,
//   index, data); it is always ready and should only be used while idle.
// Sequence:
//   One sample at a time. After acceptance the sequencer reads the four history
//   slots through the one read port, then a single shared multiplier does the
//   battery gain, the pressure span and a reciprocal multiply for the divide by
//   13263. An ignored channel skips the history reads, a non-battery channel
//   skips the battery scaling and a pressure sum at or below the zero offset
//   skips the divide. tready rises in the cycle the result turns valid.
// Reset: synchronous, active low. Pointers and history valid bits clear at
//   once so all history reads as zero; pressure sum, flag and registers reset.
// Back-pressure: a stalled result waits in the output register while the next
//   sample is processed; that one then waits until the register is free.
// ----------------------------------------------------------------------------
module multichannel_adc_moving_sum_scaler #(
    parameter int CHANNELS = mams_pkg::CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [3:0] channel, [15:4] sample
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [3:0] channel_out, [17:4] window_sum,
                                          // [26:18] battery_tenths, [27] charge_ok,
                                          // [43:28] pressure_scaled, [47:44] zero
    // Configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mams_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW    = CW + 2;
    localparam int DEPTH = CHANNELS * 4;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_BMUL = 8'b0000_0100,
        S_BSCL = 8'b0000_1000,
        S_PMUL = 8'b0001_0000,
        S_PADD = 8'b0010_0000,
        S_QUO  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    // Configuration registers
    logic [15:0]                  r_full_scale;
    logic [mams_pkg::CH_W-1:0]    r_batt_ch;
    logic [mams_pkg::CH_W-1:0]    r_pres_ch;
    logic [mams_pkg::TEN_W-1:0]   r_chg_on;
    logic [mams_pkg::TEN_W-1:0]   r_chg_off;

    // Sequencer and datapath
    t_state                       r_state, n_state;
    logic [4:0]                   r_cnt, n_cnt;
    logic [mams_pkg::CH_W-1:0]    r_ch, n_ch;
    logic                         r_inrange, n_inrange;
    logic [mams_pkg::SUM_W-1:0]   r_acc, n_acc;
    logic [mams_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic [mams_pkg::QUO_W-1:0]   r_dvd, n_dvd;

    // Latched state
    logic [mams_pkg::SUM_W-1:0]   r_psum, n_psum;
    logic [mams_pkg::TEN_W-1:0]   r_batt_ten, n_batt_ten;
    logic                         r_chg_flag, n_chg_flag;
    logic [1:0]                   r_ptr [CHANNELS];
    logic                         r_hv  [DEPTH];

    // History memory
    logic [mams_pkg::SMP_W-1:0]   r_hist [DEPTH];
    logic [mams_pkg::SMP_W-1:0]   r_rd_data;
    logic                         r_rd_live;

    // Output register
    logic                         r_m_valid, n_m_valid;
    logic [47:0]                  r_m_data, n_m_data;

    // Input decode
    logic                         in_xfer;
    logic [mams_pkg::CH_W-1:0]    in_ch;
    logic [mams_pkg::SMP_W-1:0]   in_smp;
    logic                         in_ok;
    logic [CW-1:0]                in_idx;
    logic [1:0]                   wr_slot;
    logic [AW-1:0]                wr_addr;
    logic                         wr_en;
    logic [AW-1:0]                rd_addr;
    logic                         rd_en;

    // Shared multiplier and friends
    logic [mams_pkg::PROD_W-1:0]  mul_a;
    logic [mams_pkg::RECIP_W-1:0] mul_b;
    logic [mams_pkg::PROD_W+mams_pkg::RECIP_W-1:0] mul_p;
    logic [mams_pkg::SUM_W-1:0]   psum_off;
    logic [mams_pkg::PROD_W:0]    batt_rnd;
    logic [mams_pkg::TEN_W-1:0]   batt_new;
    logic [mams_pkg::PROD_W-1:0]  dividend;
    logic                         upd_batt;
    logic                         upd_pres;
    logic                         out_free;
    logic [15:0]                  pres_out;
    logic                         ptr_we;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    assign in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ch   = i_s_axis_tdata[3:0];
    assign in_smp  = i_s_axis_tdata[15:4];
    assign in_ok   = ({3'b000, in_ch} < CH_LIMIT);
    assign in_idx  = CW'(in_ch);
    assign wr_slot = r_ptr[in_idx] + 2'd1;
    assign wr_addr = {in_idx, wr_slot};
    assign wr_en   = in_xfer && in_ok;
    assign ptr_we  = wr_en;

    assign rd_en   = (r_state == S_RD) && (r_cnt < 5'd4);
    assign rd_addr = {CW'(r_ch), r_cnt[1:0]};

    assign upd_batt = r_inrange && (r_ch == r_batt_ch);
    assign upd_pres = r_inrange && (r_ch == r_pres_ch);

    // Single multiplier: battery gain, pressure span or span reciprocal
    assign psum_off = r_psum - mams_pkg::PRES_ZERO;
    assign mul_a    = (r_state == S_BMUL) ? mams_pkg::PROD_W'(r_acc) :
                      (r_state == S_PMUL) ? mams_pkg::PROD_W'(psum_off) : r_prod;
    assign mul_b    = (r_state == S_BMUL) ? mams_pkg::RECIP_W'(mams_pkg::BATT_MULT) :
                      (r_state == S_PMUL) ? mams_pkg::RECIP_W'(r_full_scale) :
                                            mams_pkg::PRES_RECIP;
    assign mul_p    = mul_a * mul_b;

    assign batt_rnd = {1'b0, r_prod} + mams_pkg::BATT_ROUND;
    assign batt_new = batt_rnd[24:16];
    assign dividend = r_prod + mams_pkg::PRES_ROUND;

    assign out_free = !r_m_valid || i_m_axis_tready;
    assign pres_out = r_dvd[mams_pkg::QUO_W-1] ? 16'hFFFF : r_dvd[15:0];

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_ch       = r_ch;
        n_inrange  = r_inrange;
        n_acc      = r_acc;
        n_prod     = r_prod;
        n_dvd      = r_dvd;
        n_psum     = r_psum;
        n_batt_ten = r_batt_ten;
        n_chg_flag = r_chg_flag;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_data   = r_m_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_ch      = in_ch;
                    n_inrange = in_ok;
                    n_acc     = '0;
                    n_cnt     = '0;
                    n_state   = in_ok ? S_RD : S_BMUL;
                end
            end
            S_RD: begin
                // read data is registered and arrives in the cycle after its address
                if (r_cnt != 5'd0 && r_rd_live) begin
                    n_acc = r_acc + mams_pkg::SUM_W'(r_rd_data);
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd4) begin
                    n_state = S_BMUL;
                end
            end
            S_BMUL: begin
                if (upd_pres) begin
                    n_psum = r_acc;
                end
                if (upd_batt) begin
                    n_prod  = mul_p[mams_pkg::PROD_W-1:0];
                    n_state = S_BSCL;
                end else begin
                    n_state = S_PMUL;
                end
            end
            S_BSCL: begin
                n_batt_ten = batt_new;
                if (batt_new > r_chg_on) begin
                    n_chg_flag = 1'b1;
                end else if (batt_new < r_chg_off) begin
                    n_chg_flag = 1'b0;
                end
                n_state = S_PMUL;
            end
            S_PMUL: begin
                if (r_psum <= mams_pkg::PRES_ZERO) begin
                    n_dvd   = '0;
                    n_state = S_DONE;
                end else begin
                    n_prod  = mul_p[mams_pkg::PROD_W-1:0];
                    n_state = S_PADD;
                end
            end
            S_PADD: begin
                n_prod  = dividend;
                n_state = S_QUO;
            end
            S_QUO: begin
                // quotient is the product shifted down by the reciprocal scale
                n_dvd   = mul_p[mams_pkg::RECIP_SH+mams_pkg::QUO_W-1:mams_pkg::RECIP_SH];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'b0000, pres_out, r_chg_flag, r_batt_ten, r_acc, r_ch};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and latched state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_inrange    <= 1'b0;
            r_psum       <= '0;
            r_batt_ten   <= '0;
            r_chg_flag   <= 1'b0;
            r_m_valid    <= 1'b0;
            r_full_scale <= mams_pkg::RST_FULL_SCALE;
            r_batt_ch    <= mams_pkg::RST_BATT_CH;
            r_pres_ch    <= mams_pkg::RST_PRES_CH;
            r_chg_on     <= mams_pkg::RST_CHG_ON;
            r_chg_off    <= mams_pkg::RST_CHG_OFF;
            for (int i = 0; i < CHANNELS; i++) begin
                r_ptr[i] <= 2'd0;
            end
            for (int i = 0; i < DEPTH; i++) begin
                r_hv[i] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_inrange  <= n_inrange;
            r_psum     <= n_psum;
            r_batt_ten <= n_batt_ten;
            r_chg_flag <= n_chg_flag;
            r_m_valid  <= n_m_valid;
            if (ptr_we) begin
                r_ptr[in_idx] <= wr_slot;
                r_hv[wr_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mams_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data;
                    mams_pkg::CFG_BATT_CH:    r_batt_ch    <= i_cfg_data[3:0];
                    mams_pkg::CFG_PRES_CH:    r_pres_ch    <= i_cfg_data[3:0];
                    mams_pkg::CFG_CHG_ON:     r_chg_on     <= i_cfg_data[8:0];
                    mams_pkg::CFG_CHG_OFF:    r_chg_off    <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
        r_dvd    <= n_dvd;
        r_m_data <= n_m_data;
    end

    // History memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_hist[wr_addr] <= in_smp;
        end
        if (rd_en) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    // Entry validity travels with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_live <= 1'b0;
        end else if (rd_en) begin
            r_rd_live <= r_hv[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    // largest quotient: full window, full scale
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_dvd <= mams_pkg::QUO_W'(72744)))
        else $error("pressure quotient out of range");

    a_batt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_batt_ten <= 9'd343)
        else $error("battery tenths out of range");

    a_skip_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_inrange) |-> (r_acc == '0))
        else $error("ignored channel gave a non-zero sum");

    a_load_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_m_valid && r_state == S_IDLE))
        else $error("finished result not loaded");

endmodule
